[hdl/eight_bit_cpu_subset_core_assert.svh]
// Assertion macros for the CPU subset core.
`ifndef EIGHT_BIT_CPU_SUBSET_CORE_ASSERT_SVH
`define EIGHT_BIT_CPU_SUBSET_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define CPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/escc_pkg.sv]
// Package: types, codes and cycle table of the CPU subset core.
package escc_pkg;
    localparam logic [15:0] START_ADDRESS_RESET = 16'h0100;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WACK  = 2'd2;

    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_HALT  = 2'd2;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_FETCH    = 3'd1;
    localparam logic [2:0] PH_OPER1    = 3'd2;
    localparam logic [2:0] PH_OPER2    = 3'd3;
    localparam logic [2:0] PH_DATA     = 3'd4;
    localparam logic [2:0] PH_WACK     = 3'd5;
    localparam logic [2:0] PH_WACK_LOW = 3'd6;

    localparam logic [3:0] FZ = 4'b1000;
    localparam logic [3:0] FN = 4'b0100;
    localparam logic [3:0] FH = 4'b0010;
    localparam logic [3:0] FC = 4'b0001;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  access;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        opcode_fetch;
        logic [4:0]  cycles;
        logic [3:0]  flags;
    } out_item_t;

    function automatic logic [4:0] cycle_count(input logic [7:0] opc);
        logic [4:0] c;
        c = 5'd4;
        case (opc)
            8'h01, 8'h11, 8'h21, 8'h31: c = 5'd12;
            8'h08:                      c = 5'd20;
            8'h02, 8'h03, 8'h06, 8'h09, 8'h0A, 8'h0B,
            8'h12, 8'h13, 8'h16, 8'h19, 8'h1A, 8'h1B, 8'h1E,
            8'h20, 8'h22, 8'h2E, 8'h30, 8'h32, 8'h3E, 8'hFE: c = 5'd8;
            8'h18:                      c = 5'd12;
            8'hC3, 8'hE0, 8'hF0:        c = (opc == 8'hC3) ? 5'd16 : 5'd12;
            default:                    c = 5'd4;
        endcase
        return c;
    endfunction
endpackage

[hdl/eight_bit_cpu_subset_core.sv]
// Top level: bus-cycle CPU subset core with registered request output.
//
// Input channel (in_valid/in_stall/in_item): one bus event per item, a
// start token, a read byte or a write acknowledgment. Output channel
// (out_valid/out_stall/out_item): exactly one bus request per input item.
// Config channel (cfg_valid/cfg_ready/cfg_data): start address, to be
// written only while idle (core does not check); cfg_ready is always high.
// The request for an item is registered and appears on the output the
// cycle after acceptance. One item per cycle is taken while the input is
// not stalled; a single decode/execute stage feeds the output register.
// When the receiver stalls, the held request stays on the output and the
// input is stalled only while the output register is full and stalled.
// Reset clears all registers, loads the start address 0x100 and leaves
// the core waiting for a start token; the output is empty.
// An unimplemented opcode halts the core until the next start token.
module eight_bit_cpu_subset_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  escc_pkg::in_item_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output escc_pkg::out_item_t out_item
);
    import escc_pkg::*;

    logic [15:0] start_reg;
    logic [7:0]  a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, opc_reg, imm_reg;
    logic [7:0]  a_next, b_next, c_next, d_next, e_next, h_next, l_next, opc_next, imm_next;
    logic [3:0]  f_reg, f_next;
    logic [15:0] sp_reg, pc_reg, sp_next, pc_next;
    logic        ie_reg, ie_next, halt_reg, halt_next;
    logic [2:0]  ph_reg, ph_next;
    logic [1:0]  rqa_reg, rqa_next;
    logic [15:0] rqad_reg, rqad_next;
    logic [7:0]  rqd_reg, rqd_next;
    logic        rqf_reg, rqf_next;
    logic [4:0]  cyc;
    logic        ov_reg;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = ov_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;

    always_comb
    begin
        logic [7:0]  rb, t8;
        logic [15:0] t16, hl, rr;
        logic [16:0] s17;
        logic [8:0]  s9;
        logic        fin, jr;
        rb = in_item.read_data;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; h_next = h_reg; l_next = l_reg; f_next = f_reg;
        sp_next = sp_reg; pc_next = pc_reg; ie_next = ie_reg; halt_next = halt_reg;
        ph_next = ph_reg; opc_next = opc_reg; imm_next = imm_reg;
        rqa_next = rqa_reg; rqad_next = rqad_reg; rqd_next = rqd_reg; rqf_next = rqf_reg;
        cyc = 5'd0; fin = 1'b0; jr = 1'b0;
        hl = {h_reg, l_reg};
        rr = 16'd0; t8 = 8'd0; t16 = 16'd0; s17 = 17'd0; s9 = 9'd0;
        if (in_item.op == OP_START)
        begin
            halt_next = 1'b0;
            pc_next = start_reg;
            rqa_next = ACC_READ; rqad_next = start_reg; rqd_next = 8'd0; rqf_next = 1'b1;
            ph_next = PH_FETCH;
        end
        else if (!halt_reg)
        begin
            unique case (ph_reg)
                PH_FETCH:
                    if (in_item.op == OP_READ)
                    begin
                        opc_next = rb;
                        pc_next = pc_reg + 16'd1;
                        case (rb)
                            8'h00: fin = 1'b1;
                            8'h03, 8'h0B:
                            begin
                                t16 = (rb == 8'h03) ? {b_reg, c_reg} + 16'd1
                                                    : {b_reg, c_reg} - 16'd1;
                                {b_next, c_next} = t16; fin = 1'b1;
                            end
                            8'h13, 8'h1B:
                            begin
                                t16 = (rb == 8'h13) ? {d_reg, e_reg} + 16'd1
                                                    : {d_reg, e_reg} - 16'd1;
                                {d_next, e_next} = t16; fin = 1'b1;
                            end
                            8'h04, 8'h0C, 8'h14, 8'h1C, 8'h05, 8'h0D, 8'h15, 8'h1D:
                            begin
                                case (rb[4:3])
                                    2'd0: t8 = b_reg;
                                    2'd1: t8 = c_reg;
                                    2'd2: t8 = d_reg;
                                    default: t8 = e_reg;
                                endcase
                                if (rb[0])
                                begin
                                    f_next = (f_reg & FC) | FN | ((t8 == 8'd1) ? FZ : 4'd0)
                                           | ((t8[3:0] == 4'h0) ? FH : 4'd0);
                                    t8 = t8 - 8'd1;
                                end
                                else
                                begin
                                    f_next = (f_reg & FC) | ((t8 == 8'hFF) ? FZ : 4'd0)
                                           | ((t8[3:0] == 4'hF) ? FH : 4'd0);
                                    t8 = t8 + 8'd1;
                                end
                                case (rb[4:3])
                                    2'd0: b_next = t8;
                                    2'd1: c_next = t8;
                                    2'd2: d_next = t8;
                                    default: e_next = t8;
                                endcase
                                fin = 1'b1;
                            end
                            8'h07:
                            begin
                                f_next = a_reg[7] ? FC : 4'd0;
                                a_next = {a_reg[6:0], a_reg[7]};
                                fin = 1'b1;
                            end
                            8'h09, 8'h19:
                            begin
                                rr = rb[4] ? {d_reg, e_reg} : {b_reg, c_reg};
                                s17 = {1'b0, hl} + {1'b0, rr};
                                f_next = (f_reg & FZ)
                                       | (({1'b0, hl[11:0]} + {1'b0, rr[11:0]}) > 13'hFFF
                                          ? FH : 4'd0)
                                       | (s17[16] ? FC : 4'd0);
                                {h_next, l_next} = s17[15:0];
                                fin = 1'b1;
                            end
                            8'h80:
                            begin
                                s9 = {1'b0, a_reg} + {1'b0, b_reg};
                                f_next = ((s9[7:0] == 8'd0) ? FZ : 4'd0)
                                       | (({1'b0, a_reg[3:0]} + {1'b0, b_reg[3:0]}) > 5'hF
                                          ? FH : 4'd0)
                                       | (s9[8] ? FC : 4'd0);
                                a_next = s9[7:0];
                                fin = 1'b1;
                            end
                            8'hAF: begin a_next = 8'd0; f_next = FZ; fin = 1'b1; end
                            8'hF3: begin ie_next = 1'b0; fin = 1'b1; end
                            8'hFB: begin ie_next = 1'b1; fin = 1'b1; end
                            8'h02, 8'h12:
                            begin
                                rqa_next = ACC_WRITE; rqd_next = a_reg; rqf_next = 1'b0;
                                rqad_next = rb[4] ? {d_reg, e_reg} : {b_reg, c_reg};
                                ph_next = PH_WACK;
                            end
                            8'h22, 8'h32:
                            begin
                                rqa_next = ACC_WRITE; rqad_next = hl; rqd_next = a_reg;
                                rqf_next = 1'b0;
                                {h_next, l_next} = rb[4] ? hl - 16'd1 : hl + 16'd1;
                                ph_next = PH_WACK;
                            end
                            8'h0A, 8'h1A:
                            begin
                                rqa_next = ACC_READ; rqd_next = 8'd0; rqf_next = 1'b0;
                                rqad_next = rb[4] ? {d_reg, e_reg} : {b_reg, c_reg};
                                ph_next = PH_DATA;
                            end
                            8'h01, 8'h08, 8'h11, 8'h21, 8'h31, 8'hC3,
                            8'h06, 8'h0E, 8'h10, 8'h16, 8'h18, 8'h1E,
                            8'h20, 8'h2E, 8'h30, 8'h3E, 8'hE0, 8'hF0, 8'hFE:
                            begin
                                rqa_next = ACC_READ; rqad_next = pc_reg + 16'd1;
                                rqd_next = 8'd0; rqf_next = 1'b0;
                                pc_next = pc_reg + 16'd2;
                                ph_next = PH_OPER1;
                            end
                            default:
                            begin
                                pc_next = pc_reg;
                                halt_next = 1'b1;
                                rqa_next = ACC_HALT; rqad_next = pc_reg; rqd_next = 8'd0;
                                rqf_next = 1'b0;
                            end
                        endcase
                    end
                PH_OPER1:
                    if (in_item.op == OP_READ)
                    begin
                        fin = 1'b1;
                        case (opc_reg)
                            8'h01, 8'h08, 8'h11, 8'h21, 8'h31, 8'hC3:
                            begin
                                fin = 1'b0;
                                imm_next = rb;
                                rqa_next = ACC_READ; rqad_next = pc_reg; rqd_next = 8'd0;
                                rqf_next = 1'b0;
                                pc_next = pc_reg + 16'd1;
                                ph_next = PH_OPER2;
                            end
                            8'h06: b_next = rb;
                            8'h0E: c_next = rb;
                            8'h16: d_next = rb;
                            8'h1E: e_next = rb;
                            8'h2E: l_next = rb;
                            8'h3E: a_next = rb;
                            8'h18: jr = 1'b1;
                            8'h20: jr = !f_reg[3];
                            8'h30: jr = !f_reg[0];
                            8'hFE:
                            begin
                                t8 = a_reg - rb;
                                f_next = ((t8 == 8'd0) ? FZ : 4'd0) | FN
                                       | ((a_reg[3:0] < rb[3:0]) ? FH : 4'd0)
                                       | ((a_reg < rb) ? FC : 4'd0);
                            end
                            8'hE0, 8'hF0:
                            begin
                                fin = 1'b0;
                                rqad_next = {8'hFF, rb};
                                rqf_next = 1'b0;
                                if (opc_reg == 8'hE0)
                                begin
                                    rqa_next = ACC_WRITE; rqd_next = a_reg; ph_next = PH_WACK;
                                end
                                else
                                begin
                                    rqa_next = ACC_READ; rqd_next = 8'd0; ph_next = PH_DATA;
                                end
                            end
                            default: ;
                        endcase
                        if (jr)
                            pc_next = pc_reg + {{8{rb[7]}}, rb};
                    end
                PH_OPER2:
                    if (in_item.op == OP_READ)
                    begin
                        fin = 1'b1;
                        case (opc_reg)
                            8'h01: begin b_next = rb; c_next = imm_reg; end
                            8'h11: begin d_next = rb; e_next = imm_reg; end
                            8'h21: begin h_next = rb; l_next = imm_reg; end
                            8'h31: sp_next = {rb, imm_reg};
                            8'hC3: pc_next = {rb, imm_reg};
                            default:
                            begin
                                fin = 1'b0;
                                rqa_next = ACC_WRITE; rqad_next = {rb, imm_reg};
                                rqd_next = sp_reg[7:0]; rqf_next = 1'b0;
                                ph_next = PH_WACK_LOW;
                            end
                        endcase
                    end
                PH_DATA:
                    if (in_item.op == OP_READ)
                    begin
                        a_next = rb; fin = 1'b1;
                    end
                PH_WACK:
                    if (in_item.op == OP_WACK)
                        fin = 1'b1;
                PH_WACK_LOW:
                    if (in_item.op == OP_WACK)
                    begin
                        rqa_next = ACC_WRITE; rqad_next = rqad_reg + 16'd1;
                        rqd_next = sp_reg[15:8]; rqf_next = 1'b0;
                        ph_next = PH_WACK;
                    end
                default: ;
            endcase
            if (fin)
            begin
                rqa_next = ACC_READ; rqad_next = pc_next; rqd_next = 8'd0; rqf_next = 1'b1;
                cyc = cycle_count(opc_next);
                ph_next = PH_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_ADDRESS_RESET;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0; e_reg <= '0;
            h_reg <= '0; l_reg <= '0; f_reg <= '0; sp_reg <= '0;
            pc_reg <= START_ADDRESS_RESET; ie_reg <= 1'b0; halt_reg <= 1'b0;
            ph_reg <= PH_IDLE; opc_reg <= '0; imm_reg <= '0;
            rqa_reg <= ACC_READ; rqad_reg <= '0; rqd_reg <= '0; rqf_reg <= 1'b0;
            ov_reg <= 1'b0;
            out_item <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                start_reg <= cfg_data;
            if (accept)
            begin
                a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
                e_reg <= e_next; h_reg <= h_next; l_reg <= l_next; f_reg <= f_next;
                sp_reg <= sp_next; pc_reg <= pc_next; ie_reg <= ie_next;
                halt_reg <= halt_next; ph_reg <= ph_next; opc_reg <= opc_next;
                imm_reg <= imm_next;
                rqa_reg <= rqa_next; rqad_reg <= rqad_next; rqd_reg <= rqd_next;
                rqf_reg <= rqf_next;
                out_item <= '{access: rqa_next, address: rqad_next, write_data: rqd_next,
                              opcode_fetch: rqf_next, cycles: cyc, flags: f_next};
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

`include "eight_bit_cpu_subset_core_assert.svh"

    `CPU_ASSERT_NEXT(a_start_fetch, clk, rst_n, accept && in_item.op == OP_START, out_valid && out_item.opcode_fetch && out_item.address == $past(start_reg), "start must fetch at start address")
    `CPU_ASSERT_IMP(a_halt_access, clk, rst_n, out_valid && halt_reg, out_item.access == ACC_HALT, "halted core must report halt")
    `CPU_ASSERT_IMP(a_cycles_fetch, clk, rst_n, out_valid && out_item.cycles != 5'd0, out_item.opcode_fetch, "cycle count only on opcode fetch")
    `CPU_ASSERT_NEXT(a_one_result, clk, rst_n, accept, out_valid, "every accepted item yields a result")
endmodule

[bench/tb_eight_bit_cpu_subset_core.sv]
// Testbench for the CPU subset core: scoreboard against an in-bench bus-cycle predictor.
`timescale 1ns / 1ps

module tb_eight_bit_cpu_subset_core;
    import escc_pkg::*;

    localparam int LIMIT = 100000;
    localparam int PHASE_ITEMS = 340;

    localparam logic [7:0] O_NOP = 8'h00, O_LD_BC = 8'h01, O_ST_BC = 8'h02, O_INC_BC = 8'h03;
    localparam logic [7:0] O_INC_B = 8'h04, O_DEC_B = 8'h05, O_LD_B = 8'h06, O_RLCA = 8'h07;
    localparam logic [7:0] O_ST_SP = 8'h08, O_ADD_HL_BC = 8'h09, O_LDA_BC = 8'h0A;
    localparam logic [7:0] O_DEC_BC = 8'h0B, O_INC_C = 8'h0C, O_DEC_C = 8'h0D, O_LD_C = 8'h0E;
    localparam logic [7:0] O_STOP = 8'h10, O_LD_DE = 8'h11, O_ST_DE = 8'h12, O_INC_DE = 8'h13;
    localparam logic [7:0] O_INC_D = 8'h14, O_DEC_D = 8'h15, O_LD_D = 8'h16, O_JR = 8'h18;
    localparam logic [7:0] O_ADD_HL_DE = 8'h19, O_LDA_DE = 8'h1A, O_DEC_DE = 8'h1B;
    localparam logic [7:0] O_INC_E = 8'h1C, O_DEC_E = 8'h1D, O_LD_E = 8'h1E, O_JR_NZ = 8'h20;
    localparam logic [7:0] O_LD_HL = 8'h21, O_ST_HLI = 8'h22, O_LD_L = 8'h2E, O_JR_NC = 8'h30;
    localparam logic [7:0] O_LD_SP = 8'h31, O_ST_HLD = 8'h32, O_LD_A = 8'h3E;
    localparam logic [7:0] O_ADD_A_B = 8'h80, O_XOR_A = 8'hAF, O_JP = 8'hC3;
    localparam logic [7:0] O_LDH_ST = 8'hE0, O_LDH_LD = 8'hF0, O_DI = 8'hF3, O_EI = 8'hFB;
    localparam logic [7:0] O_CP = 8'hFE, O_BAD = 8'hD3;
    localparam logic [1:0] OP_JUNK = 2'd3;

    localparam logic [7:0] OPCODES [45] = '{
        O_NOP, O_LD_BC, O_ST_BC, O_INC_BC, O_INC_B, O_DEC_B, O_LD_B, O_RLCA, O_ST_SP,
        O_ADD_HL_BC, O_LDA_BC, O_DEC_BC, O_INC_C, O_DEC_C, O_LD_C, O_STOP, O_LD_DE,
        O_ST_DE, O_INC_DE, O_INC_D, O_DEC_D, O_LD_D, O_JR, O_ADD_HL_DE, O_LDA_DE,
        O_DEC_DE, O_INC_E, O_DEC_E, O_LD_E, O_JR_NZ, O_LD_HL, O_ST_HLI, O_LD_L, O_JR_NC,
        O_LD_SP, O_ST_HLD, O_LD_A, O_ADD_A_B, O_XOR_A, O_JP, O_LDH_ST, O_LDH_LD, O_DI,
        O_EI, O_CP};

    typedef struct {
        logic [15:0] start_addr;
        logic [7:0]  a, b, c, d, e, h, l;
        logic [3:0]  f;
        logic [15:0] sp, pc;
        logic        ie, halted;
        logic [2:0]  phase;
        logic [7:0]  opc, imm;
        out_item_t   req;
    } cpu_state_t;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [15:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    in_item_t in_item;
    out_item_t out_item;

    cpu_state_t pred_st, gen_st;
    in_item_t pending_items[$];
    out_item_t expected_reqs[$];
    int errors = 0;
    int cycle_cnt = 0;
    int send_idle = 0, recv_stall = 0;
    int hold_cnt = 0;

    eight_bit_cpu_subset_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    function automatic logic [4:0] instr_cycles(input logic [7:0] opc);
        case (opc)
            O_ST_SP: return 5'd20;
            O_JP: return 5'd16;
            O_LD_BC, O_LD_DE, O_LD_HL, O_LD_SP, O_JR, O_LDH_ST, O_LDH_LD: return 5'd12;
            O_ST_BC, O_INC_BC, O_LD_B, O_ADD_HL_BC, O_LDA_BC, O_DEC_BC,
            O_ST_DE, O_INC_DE, O_LD_D, O_ADD_HL_DE, O_LDA_DE, O_DEC_DE, O_LD_E,
            O_JR_NZ, O_ST_HLI, O_LD_L, O_JR_NC, O_ST_HLD, O_LD_A, O_CP: return 5'd8;
            default: return 5'd4;
        endcase
    endfunction

    function automatic void cpu_reset(ref cpu_state_t s);
        s.start_addr = START_ADDRESS_RESET;
        s.a = '0; s.b = '0; s.c = '0; s.d = '0; s.e = '0; s.h = '0; s.l = '0; s.f = '0;
        s.sp = '0; s.pc = START_ADDRESS_RESET;
        s.ie = 1'b0; s.halted = 1'b0; s.phase = PH_IDLE; s.opc = '0; s.imm = '0;
        s.req = '0;
    endfunction

    function automatic void set_req(ref cpu_state_t s, input logic [1:0] acc,
                                    input logic [15:0] addr, input logic [7:0] data,
                                    input logic fetch);
        s.req = '0;
        s.req.access = acc;
        s.req.address = addr;
        s.req.write_data = data;
        s.req.opcode_fetch = fetch;
    endfunction

    function automatic void read_next(ref cpu_state_t s, input logic [2:0] nxt);
        set_req(s, ACC_READ, s.pc, 8'h00, 1'b0);
        s.pc = s.pc + 16'd1;
        s.phase = nxt;
    endfunction

    function automatic logic [7:0] incr8(ref cpu_state_t s, input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'd1;
        s.f = (s.f & FC) | ((r == 8'd0) ? FZ : 4'b0) | ((v[3:0] == 4'hF) ? FH : 4'b0);
        return r;
    endfunction

    function automatic logic [7:0] decr8(ref cpu_state_t s, input logic [7:0] v);
        logic [7:0] r;
        r = v - 8'd1;
        s.f = (s.f & FC) | ((r == 8'd0) ? FZ : 4'b0) | FN | ((v[3:0] == 4'h0) ? FH : 4'b0);
        return r;
    endfunction

    function automatic void add_to_hl(ref cpu_state_t s, input logic [15:0] rr);
        logic [16:0] sum;
        logic [12:0] low;
        sum = {1'b0, s.h, s.l} + {1'b0, rr};
        low = {1'b0, s.h[3:0], s.l} + {1'b0, rr[11:0]};
        s.f = (s.f & FZ) | (low[12] ? FH : 4'b0) | (sum[16] ? FC : 4'b0);
        {s.h, s.l} = sum[15:0];
    endfunction

    // one bus event in, next bus request out
    function automatic out_item_t cpu_step(ref cpu_state_t s, input in_item_t it);
        logic [7:0] v, r;
        logic [15:0] t, at, w;
        logic [8:0] s9;
        logic [4:0] s5;
        logic [4:0] cyc;
        logic fin;
        out_item_t o;
        v = it.read_data;
        fin = 1'b0;
        cyc = 5'd0;
        if (it.op == OP_START)
        begin
            s.halted = 1'b0;
            s.pc = s.start_addr;
            set_req(s, ACC_READ, s.pc, 8'h00, 1'b1);
            s.phase = PH_FETCH;
        end
        else if (!s.halted)
        begin
            case (s.phase)
                PH_FETCH:
                    if (it.op == OP_READ)
                    begin
                        at = s.pc;
                        s.opc = v;
                        s.pc = s.pc + 16'd1;
                        case (v)
                            O_NOP: fin = 1'b1;
                            O_INC_BC, O_DEC_BC:
                            begin
                                t = (v == O_INC_BC) ? {s.b, s.c} + 16'd1 : {s.b, s.c} - 16'd1;
                                {s.b, s.c} = t;
                                fin = 1'b1;
                            end
                            O_INC_DE, O_DEC_DE:
                            begin
                                t = (v == O_INC_DE) ? {s.d, s.e} + 16'd1 : {s.d, s.e} - 16'd1;
                                {s.d, s.e} = t;
                                fin = 1'b1;
                            end
                            O_INC_B: begin s.b = incr8(s, s.b); fin = 1'b1; end
                            O_DEC_B: begin s.b = decr8(s, s.b); fin = 1'b1; end
                            O_INC_C: begin s.c = incr8(s, s.c); fin = 1'b1; end
                            O_DEC_C: begin s.c = decr8(s, s.c); fin = 1'b1; end
                            O_INC_D: begin s.d = incr8(s, s.d); fin = 1'b1; end
                            O_DEC_D: begin s.d = decr8(s, s.d); fin = 1'b1; end
                            O_INC_E: begin s.e = incr8(s, s.e); fin = 1'b1; end
                            O_DEC_E: begin s.e = decr8(s, s.e); fin = 1'b1; end
                            O_RLCA:
                            begin
                                s.f = s.a[7] ? FC : 4'b0;
                                s.a = {s.a[6:0], s.a[7]};
                                fin = 1'b1;
                            end
                            O_ADD_HL_BC: begin add_to_hl(s, {s.b, s.c}); fin = 1'b1; end
                            O_ADD_HL_DE: begin add_to_hl(s, {s.d, s.e}); fin = 1'b1; end
                            O_ADD_A_B:
                            begin
                                s9 = {1'b0, s.a} + {1'b0, s.b};
                                s5 = {1'b0, s.a[3:0]} + {1'b0, s.b[3:0]};
                                r = s9[7:0];
                                s.f = ((r == 8'd0) ? FZ : 4'b0) | (s5[4] ? FH : 4'b0)
                                    | (s9[8] ? FC : 4'b0);
                                s.a = r;
                                fin = 1'b1;
                            end
                            O_XOR_A: begin s.a = 8'd0; s.f = FZ; fin = 1'b1; end
                            O_DI: begin s.ie = 1'b0; fin = 1'b1; end
                            O_EI: begin s.ie = 1'b1; fin = 1'b1; end
                            O_ST_BC:
                            begin
                                set_req(s, ACC_WRITE, {s.b, s.c}, s.a, 1'b0);
                                s.phase = PH_WACK;
                            end
                            O_ST_DE:
                            begin
                                set_req(s, ACC_WRITE, {s.d, s.e}, s.a, 1'b0);
                                s.phase = PH_WACK;
                            end
                            O_ST_HLI, O_ST_HLD:
                            begin
                                t = {s.h, s.l};
                                set_req(s, ACC_WRITE, t, s.a, 1'b0);
                                t = (v == O_ST_HLI) ? t + 16'd1 : t - 16'd1;
                                {s.h, s.l} = t;
                                s.phase = PH_WACK;
                            end
                            O_LDA_BC:
                            begin
                                set_req(s, ACC_READ, {s.b, s.c}, 8'h00, 1'b0);
                                s.phase = PH_DATA;
                            end
                            O_LDA_DE:
                            begin
                                set_req(s, ACC_READ, {s.d, s.e}, 8'h00, 1'b0);
                                s.phase = PH_DATA;
                            end
                            O_LD_BC, O_ST_SP, O_LD_DE, O_LD_HL, O_LD_SP, O_JP,
                            O_LD_B, O_LD_C, O_STOP, O_LD_D, O_JR, O_LD_E,
                            O_JR_NZ, O_LD_L, O_JR_NC, O_LD_A, O_LDH_ST, O_LDH_LD, O_CP:
                                read_next(s, PH_OPER1);
                            default:
                            begin
                                s.pc = at;
                                s.halted = 1'b1;
                                set_req(s, ACC_HALT, at, 8'h00, 1'b0);
                            end
                        endcase
                    end
                PH_OPER1:
                    if (it.op == OP_READ)
                    begin
                        fin = 1'b1;
                        case (s.opc)
                            O_LD_BC, O_ST_SP, O_LD_DE, O_LD_HL, O_LD_SP, O_JP:
                            begin
                                fin = 1'b0;
                                s.imm = v;
                                read_next(s, PH_OPER2);
                            end
                            O_LD_B: s.b = v;
                            O_LD_C: s.c = v;
                            O_LD_D: s.d = v;
                            O_LD_E: s.e = v;
                            O_LD_L: s.l = v;
                            O_LD_A: s.a = v;
                            O_JR: s.pc = s.pc + {{8{v[7]}}, v};
                            O_JR_NZ: if (s.f[3] == 1'b0) s.pc = s.pc + {{8{v[7]}}, v};
                            O_JR_NC: if (s.f[0] == 1'b0) s.pc = s.pc + {{8{v[7]}}, v};
                            O_CP:
                            begin
                                r = s.a - v;
                                s.f = ((r == 8'd0) ? FZ : 4'b0) | FN
                                    | ((s.a[3:0] < v[3:0]) ? FH : 4'b0)
                                    | ((s.a < v) ? FC : 4'b0);
                            end
                            O_LDH_ST:
                            begin
                                fin = 1'b0;
                                set_req(s, ACC_WRITE, {8'hFF, v}, s.a, 1'b0);
                                s.phase = PH_WACK;
                            end
                            O_LDH_LD:
                            begin
                                fin = 1'b0;
                                set_req(s, ACC_READ, {8'hFF, v}, 8'h00, 1'b0);
                                s.phase = PH_DATA;
                            end
                            default: ;
                        endcase
                    end
                PH_OPER2:
                    if (it.op == OP_READ)
                    begin
                        fin = 1'b1;
                        w = {v, s.imm};
                        case (s.opc)
                            O_LD_BC: begin s.b = v; s.c = s.imm; end
                            O_LD_DE: begin s.d = v; s.e = s.imm; end
                            O_LD_HL: begin s.h = v; s.l = s.imm; end
                            O_LD_SP: s.sp = w;
                            O_JP: s.pc = w;
                            default:
                            begin
                                fin = 1'b0;
                                set_req(s, ACC_WRITE, w, s.sp[7:0], 1'b0);
                                s.phase = PH_WACK_LOW;
                            end
                        endcase
                    end
                PH_DATA:
                    if (it.op == OP_READ)
                    begin
                        s.a = v;
                        fin = 1'b1;
                    end
                PH_WACK:
                    if (it.op == OP_WACK)
                        fin = 1'b1;
                PH_WACK_LOW:
                    if (it.op == OP_WACK)
                    begin
                        set_req(s, ACC_WRITE, s.req.address + 16'd1, s.sp[15:8], 1'b0);
                        s.phase = PH_WACK;
                    end
                default: ;
            endcase
            if (fin)
            begin
                set_req(s, ACC_READ, s.pc, 8'h00, 1'b1);
                cyc = instr_cycles(s.opc);
                s.phase = PH_FETCH;
            end
        end
        o = s.req;
        o.cycles = cyc;
        o.flags = s.f;
        return o;
    endfunction

    function automatic logic [1:0] junk_op();
        case ($urandom_range(2))
            0: return OP_READ;
            1: return OP_WACK;
            default: return OP_JUNK;
        endcase
    endfunction

    // picks a bus event for the pending request, now and then a start token or a junk event
    function automatic in_item_t gen_item(ref cpu_state_t s);
        in_item_t it;
        int r;
        r = $urandom_range(99);
        it.op = OP_READ;
        it.read_data = 8'($urandom_range(255));
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(4))
                0: it.read_data = 8'h00;
                1: it.read_data = 8'hFF;
                2: it.read_data = 8'h0F;
                3: it.read_data = 8'h80;
                default: it.read_data = 8'h01;
            endcase
        end
        if (s.halted || s.phase == PH_IDLE)
            it.op = (r < 50) ? OP_START : junk_op();
        else if (r < 2)
            it.op = OP_START;
        else if (r < 6)
            it.op = junk_op();
        else if (s.req.access == ACC_WRITE)
            it.op = OP_WACK;
        else if (s.req.opcode_fetch && r >= 10)
            it.read_data = OPCODES[$urandom_range(44)];
        else if (s.req.opcode_fetch && r >= 8)
            it.read_data = O_BAD;
        void'(cpu_step(s, it));
        return it;
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // long receiver hold while the sender keeps offering items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (cycle_cnt == 150)
            hold_cnt <= 90;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_cnt != 0) || ($urandom_range(99) < recv_stall);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_reqs.push_back(cpu_step(pred_st, in_item));
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    in_item <= pending_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : mon
        out_item_t exp_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reqs.size() == 0)
                report("result with no item pending");
            else
            begin
                exp_item = expected_reqs.pop_front();
                if (out_item !== exp_item)
                    report($sformatf("got %h, wanted %h", out_item, exp_item));
            end
        end
    end

    initial
    begin : stim
        int ph;
        logic [15:0] addr;
        cpu_reset(pred_st);
        cpu_reset(gen_st);
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (ph = 0; ph < 4; ph++)
        begin
            while (pending_items.size() != 0 || in_valid || expected_reqs.size() != 0)
                @(negedge clk);
            if (ph != 0)
            begin
                addr = (ph == 1) ? 16'hFFFE : 16'($urandom_range(65535));
                @(posedge clk);
                cfg_valid <= 1'b1;
                cfg_data <= addr;
                do
                    @(posedge clk);
                while (!cfg_ready);
                cfg_valid <= 1'b0;
                pred_st.start_addr = addr;
                gen_st.start_addr = addr;
            end
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 70; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 70; end
                default: begin send_idle = 38; recv_stall = 38; end
            endcase
            repeat (PHASE_ITEMS) pending_items.push_back(gen_item(gen_st));
        end
        while (pending_items.size() != 0 || in_valid || expected_reqs.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
        if (errors == 0 && expected_reqs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/escc_pkg.sv
hdl/eight_bit_cpu_subset_core.sv
bench/tb_eight_bit_cpu_subset_core.sv
